@@ src/caf8_pkg.sv @@
// ----------------------------------------------------------------------------
// caf8_pkg
// shared types and constants of the 8-bit cpu alu with z, h and c flags
// ----------------------------------------------------------------------------
`default_nettype none

package caf8_pkg;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;

  typedef enum logic [3:0] {
    OP_INC   = 4'd0,
    OP_DEC   = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_ADD16 = 4'd4,
    OP_RLC   = 4'd5,
    OP_RL    = 4'd6,
    OP_RRC   = 4'd7,
    OP_RR    = 4'd8,
    OP_SLA   = 4'd9,
    OP_SRA   = 4'd10,
    OP_SRL   = 4'd11
  } op_t;

  // first member sits in the top bits
  typedef struct packed {
    logic              flag_carry_in;
    logic              half_in;
    logic              zero_in;
    logic              carry_in;
    logic [WORD_W-1:0] operand_b;
    logic [WORD_W-1:0] operand_a;
    op_t               op;
  } alu_req_t;

  typedef struct packed {
    logic              carry_out;
    logic              half_out;
    logic              zero_out;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

  localparam int unsigned REQ_W = $bits(alu_req_t);
  localparam int unsigned RSP_W = $bits(alu_rsp_t);

endpackage

`default_nettype wire

@@ src/cpu_alu_flags_8bit.sv @@
// ----------------------------------------------------------------------------
// cpu_alu_flags_8bit
// 8-bit cpu alu with z, h and c flags, stream in and stream out
// path: item accept, input reg, alu, result reg, then result valid
// throughput: 1 item per cycle unless out_tready holds a full pipe; the alu
// is a single pass between the two regs; each stage has its own valid, so a
// held result blocks the input only once both stages are full
// reset: synchronous active-low rst_n clears both valid bits, no payload reset
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_alu_flags_8bit
  import caf8_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // op[3:0], operand_a[19:4], operand_b[35:20], carry_in[36], zero_in[37],
  // half_in[38], flag_carry_in[39]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // result[15:0], zero_out[16], half_out[17], carry_out[18], zero pad[23:19]
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  alu_req_t         req_d;
  alu_req_t         req_q;
  alu_rsp_t         rsp_d;
  alu_rsp_t         rsp_q;
  logic [REQ_W-1:0] req_bits;
  logic [RSP_W-1:0] rsp_bits;
  logic             ex_valid;
  logic             ex_ready;

  assign req_d = alu_req_t'(in_tdata[REQ_W-1:0]);

  caf8_stage #(
    .WIDTH (REQ_W)
  ) u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (req_d),
    .out_valid (ex_valid),
    .out_ready (ex_ready),
    .out_data  (req_bits)
  );

  assign req_q = alu_req_t'(req_bits);

  caf8_alu u_alu (
    .req (req_q),
    .rsp (rsp_d)
  );

  caf8_stage #(
    .WIDTH (RSP_W)
  ) u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ex_valid),
    .in_ready  (ex_ready),
    .in_data   (rsp_d),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (rsp_bits)
  );

  assign rsp_q     = alu_rsp_t'(rsp_bits);
  assign out_tdata = {{(OUT_TDATA_W-RSP_W){1'b0}}, rsp_q};

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (ex_valid && out_tvalid))
    else $error("input stalled while a stage is empty");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !ex_valid))
    else $error("pipeline not empty after reset");

  a_byte_ops_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid && req_q.op != OP_ADD16) |-> (rsp_d.result[WORD_W-1:BYTE_W] == 8'd0))
    else $error("8-bit operation drove the high byte");

  a_unused_op_passes: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_valid && req_q.op > OP_SRL) |->
      (rsp_d.zero_out == req_q.zero_in && rsp_d.half_out == req_q.half_in &&
       rsp_d.carry_out == req_q.flag_carry_in && rsp_d.result == '0))
    else $error("unused op code changed flags or result");

endmodule

`default_nettype wire

@@ src/caf8_stage.sv @@
// ----------------------------------------------------------------------------
// caf8_stage
// one registered pipeline stage with valid and ready, full rate
// ----------------------------------------------------------------------------
`default_nettype none

module caf8_stage #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [WIDTH-1:0] data_r;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

@@ src/caf8_alu.sv @@
// ----------------------------------------------------------------------------
// caf8_alu
// combinational datapath: 8-bit arithmetic, 16-bit add, rotates and shifts
// ----------------------------------------------------------------------------
`default_nettype none

module caf8_alu
  import caf8_pkg::*;
(
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);

  logic [BYTE_W-1:0] a;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W:0]   sum8;
  logic [BYTE_W:0]   dif8;
  logic [WORD_W:0]   sum16;
  logic [BYTE_W-1:0] inc8;
  logic [BYTE_W-1:0] dec8;
  logic [BYTE_W-1:0] sum8_x;
  logic [BYTE_W-1:0] dif8_x;
  logic [WORD_W-1:0] sum16_x;

  assign a       = req.operand_a[BYTE_W-1:0];
  assign b       = req.operand_b[BYTE_W-1:0];
  assign sum8    = {1'b0, a} + {1'b0, b} + {{BYTE_W{1'b0}}, req.carry_in};
  assign dif8    = {1'b0, a} - {1'b0, b} - {{BYTE_W{1'b0}}, req.carry_in};
  assign sum16   = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign inc8    = a + 8'd1;
  assign dec8    = a - 8'd1;
  assign sum8_x  = a ^ b ^ sum8[BYTE_W-1:0];
  assign dif8_x  = a ^ b ^ dif8[BYTE_W-1:0];
  assign sum16_x = req.operand_a ^ req.operand_b ^ sum16[WORD_W-1:0];

  always_comb begin
    rsp.result    = '0;
    rsp.zero_out  = req.zero_in;
    rsp.half_out  = req.half_in;
    rsp.carry_out = req.flag_carry_in;
    case (req.op)
      OP_INC: begin
        rsp.result   = {8'd0, inc8};
        rsp.zero_out = (inc8 == 8'd0);
        rsp.half_out = (inc8[3:0] == 4'h0);
      end
      OP_DEC: begin
        rsp.result   = {8'd0, dec8};
        rsp.zero_out = (dec8 == 8'd0);
        rsp.half_out = (dec8[3:0] == 4'hf);
      end
      OP_ADD: begin
        rsp.result    = {8'd0, sum8[BYTE_W-1:0]};
        rsp.zero_out  = (sum8[BYTE_W-1:0] == 8'd0);
        rsp.half_out  = sum8_x[4];
        rsp.carry_out = sum8[BYTE_W];
      end
      OP_SUB: begin
        rsp.result    = {8'd0, dif8[BYTE_W-1:0]};
        rsp.zero_out  = (dif8[BYTE_W-1:0] == 8'd0);
        rsp.half_out  = dif8_x[4];
        rsp.carry_out = dif8[BYTE_W];
      end
      OP_ADD16: begin
        rsp.result    = sum16[WORD_W-1:0];
        rsp.half_out  = sum16_x[12];
        rsp.carry_out = sum16[WORD_W];
      end
      OP_RLC: begin
        rsp.result    = {8'd0, a[6:0], a[7]};
        rsp.carry_out = a[7];
      end
      OP_RL: begin
        rsp.result    = {8'd0, a[6:0], req.flag_carry_in};
        rsp.carry_out = a[7];
      end
      OP_RRC: begin
        rsp.result    = {8'd0, a[0], a[7:1]};
        rsp.carry_out = a[0];
      end
      OP_RR: begin
        rsp.result    = {8'd0, req.flag_carry_in, a[7:1]};
        rsp.carry_out = a[0];
      end
      OP_SLA: begin
        rsp.result    = {8'd0, a[6:0], 1'b0};
        rsp.carry_out = a[7];
      end
      OP_SRA: begin
        rsp.result    = {8'd0, a[7], a[7:1]};
        rsp.carry_out = a[0];
      end
      OP_SRL: begin
        rsp.result    = {8'd0, 1'b0, a[7:1]};
        rsp.carry_out = a[0];
      end
      default: begin
        rsp.result = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ tb/alu_flags_checker.sv @@
// ----------------------------------------------------------------------------
// alu_flags_checker
// watches both streams of the 8-bit alu, predicts result and z, h, c flags
// for every accepted input item and compares them with the result items
// ----------------------------------------------------------------------------
module alu_flags_checker
  import caf8_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     outstanding,
  output int                     checked
);

  alu_rsp_t expected_flags_q[$];
  int       err_cnt = 0;
  int       chk_cnt = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    checked     = 0;
  end

  function automatic alu_rsp_t alu_flags_predict(alu_req_t req);
    alu_rsp_t        rsp;
    logic [7:0]      a;
    logic [7:0]      b;
    logic [7:0]      r8;
    logic [8:0]      s9;
    logic [16:0]     s17;
    a            = req.operand_a[7:0];
    b            = req.operand_b[7:0];
    r8           = 8'h00;
    rsp.result   = '0;
    rsp.zero_out = req.zero_in;
    rsp.half_out = req.half_in;
    rsp.carry_out = req.flag_carry_in;
    case (req.op)
      OP_INC: begin
        r8           = a + 8'd1;
        rsp.zero_out = (r8 == 8'h00);
        rsp.half_out = (r8[3:0] == 4'h0);
      end
      OP_DEC: begin
        r8           = a - 8'd1;
        rsp.zero_out = (r8 == 8'h00);
        rsp.half_out = (r8[3:0] == 4'hf);
      end
      OP_ADD: begin
        s9            = {1'b0, a} + {1'b0, b} + {8'd0, req.carry_in};
        r8            = s9[7:0];
        rsp.zero_out  = (r8 == 8'h00);
        rsp.half_out  = a[4] ^ b[4] ^ s9[4];
        rsp.carry_out = s9[8];
      end
      OP_SUB: begin
        s9            = {1'b0, a} - {1'b0, b} - {8'd0, req.carry_in};
        r8            = s9[7:0];
        rsp.zero_out  = (r8 == 8'h00);
        rsp.half_out  = a[4] ^ b[4] ^ s9[4];
        rsp.carry_out = ({1'b0, a} < ({1'b0, b} + {8'd0, req.carry_in}));
      end
      OP_ADD16: begin
        s17           = {1'b0, req.operand_a} + {1'b0, req.operand_b};
        rsp.half_out  = req.operand_a[12] ^ req.operand_b[12] ^ s17[12];
        rsp.carry_out = s17[16];
      end
      OP_RLC: begin
        rsp.carry_out = a[7];
        r8            = {a[6:0], a[7]};
      end
      OP_RL: begin
        r8            = {a[6:0], req.flag_carry_in};
        rsp.carry_out = a[7];
      end
      OP_RRC: begin
        rsp.carry_out = a[0];
        r8            = {a[0], a[7:1]};
      end
      OP_RR: begin
        r8            = {req.flag_carry_in, a[7:1]};
        rsp.carry_out = a[0];
      end
      OP_SLA: begin
        rsp.carry_out = a[7];
        r8            = {a[6:0], 1'b0};
      end
      OP_SRA: begin
        rsp.carry_out = a[0];
        r8            = {a[7], a[7:1]};
      end
      OP_SRL: begin
        rsp.carry_out = a[0];
        r8            = {1'b0, a[7:1]};
      end
      default: begin
        r8 = 8'h00;
      end
    endcase
    if (req.op == OP_ADD16) begin
      rsp.result = s17[15:0];
    end else begin
      rsp.result = {8'h00, r8};
    end
    return rsp;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    alu_req_t                      req;
    alu_rsp_t                      got;
    alu_rsp_t                      want;
    logic [OUT_TDATA_W-RSP_W-1:0]  pad;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        req = in_tdata;
        expected_flags_q.push_back(alu_flags_predict(req));
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[RSP_W-1:0];
        pad = out_tdata[OUT_TDATA_W-1:RSP_W];
        if (expected_flags_q.size() == 0) begin
          $display("%0t unexpected result item: expected none actual %h", $time, out_tdata);
          err_cnt++;
        end else begin
          want = expected_flags_q.pop_front();
          check_field("result", want.result, got.result);
          check_field("zero_out", want.zero_out, got.zero_out);
          check_field("half_out", want.half_out, got.half_out);
          check_field("carry_out", want.carry_out, got.carry_out);
          check_field("pad", '0, pad);
          chk_cnt++;
        end
      end
    end
    mismatches  <= err_cnt;
    outstanding <= expected_flags_q.size();
    checked     <= chk_cnt;
  end

endmodule

@@ tb/tb_cpu_alu_flags_8bit.sv @@
// ----------------------------------------------------------------------------
// tb_cpu_alu_flags_8bit
// drives directed corner items and about 650 random alu operations, with
// random idle bursts on both streams and one long output hold-off; a
// separate checker predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_cpu_alu_flags_8bit;
  import caf8_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 650;
  localparam int TAIL_ITEMS     = 100;
  localparam int HOLD_START     = 150;
  localparam int HOLD_CYCLES    = 48;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int OP_CODES       = 1 << $bits(op_t);

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int checked;
  int sent_cnt = 0;
  bit quiet_tail = 1'b0;

  cpu_alu_flags_8bit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  alu_flags_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  function automatic alu_req_t alu_item(op_t op, logic [15:0] a, logic [15:0] b,
                                        logic cin, logic z, logic h, logic c);
    alu_req_t req;
    req.op            = op;
    req.operand_a     = a;
    req.operand_b     = b;
    req.carry_in      = cin;
    req.zero_in       = z;
    req.half_in       = h;
    req.flag_carry_in = c;
    return req;
  endfunction

  function automatic logic [15:0] rand_operand();
    logic [7:0] corner_bytes [8];
    logic [7:0] hi;
    corner_bytes = '{8'h00, 8'h01, 8'h0f, 8'h10, 8'h7f, 8'h80, 8'hf0, 8'hff};
    hi = $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0) begin
      return {hi, corner_bytes[$urandom_range(0, 7)]};
    end
    return $urandom_range(0, 65535);
  endfunction

  function automatic alu_req_t rand_item();
    op_t op;
    if ($urandom_range(0, 9) == 0) begin
      op = op_t'($urandom_range(OP_SRL + 1, OP_CODES - 1));
    end else begin
      op = op_t'($urandom_range(OP_INC, OP_SRL));
    end
    return alu_item(op, rand_operand(), rand_operand(), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  // call right after a rising edge; returns right after the accepting edge
  task automatic send_item(alu_req_t req);
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    do @(posedge clk); while (!in_tready);
    sent_cnt++;
  endtask

  task automatic idle_in(int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off, steady in the tail
  initial begin
    int rx_cycles;
    int n;
    bit hold_done;
    rx_cycles  = 0;
    hold_done  = 1'b0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!hold_done && rx_cycles >= HOLD_START) begin
        hold_done  = 1'b1;
        out_tready <= 1'b0;
        n = HOLD_CYCLES;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk);
      rx_cycles += n;
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[cpu_alu_flags_8bit] ERROR");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_item(alu_item(OP_INC, 16'h00ff, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_INC, 16'hab0f, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(alu_item(OP_DEC, 16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(alu_item(OP_DEC, 16'hff00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_ADD, 16'h00ff, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_ADD, 16'h000f, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1));
    send_item(alu_item(OP_ADD, 16'hffff, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_SUB, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_SUB, 16'h0010, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_SUB, 16'h553c, 16'haa3c, 1'b0, 1'b0, 1'b1, 1'b1));
    send_item(alu_item(OP_ADD16, 16'hffff, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(alu_item(OP_ADD16, 16'h0fff, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(alu_item(OP_ADD16, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b1));
    send_item(alu_item(OP_RLC, 16'h0080, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0));
    send_item(alu_item(OP_RL, 16'hff80, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
    send_item(alu_item(OP_RL, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1));
    send_item(alu_item(OP_RRC, 16'h0001, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_RR, 16'h0001, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b1));
    send_item(alu_item(OP_SLA, 16'h00ff, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_SRA, 16'h7f81, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OP_SRL, 16'h0081, 16'h0000, 1'b0, 1'b1, 1'b1, 1'b0));
    // unused op codes pass the flags through
    for (int code = OP_SRL + 1; code < OP_CODES; code++) begin
      send_item(alu_item(op_t'(code), 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1, 1'b1));
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - TAIL_ITEMS) begin
        quiet_tail = 1'b1;
      end
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        idle_in($urandom_range(1, 3));
      end
      send_item(rand_item());
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: all op codes incl. unused ones, byte and word corners",
             sent_cnt);
    $display("%0d results compared; one %0d-cycle output hold-off backed up the input",
             checked, HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[cpu_alu_flags_8bit] OK");
    end else begin
      $display("[cpu_alu_flags_8bit] ERROR");
    end
    $finish;
  end

endmodule
